### rtl/core/pcs_pkg.sv
package pcs_pkg;

  localparam int QueueDepth = 16;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChSlash   = 8'h2F;

  typedef enum logic [1:0] {
    MODE_PATH   = 2'd0,
    MODE_COMP   = 2'd1,
    MODE_DECODE = 2'd2,
    MODE_KEEP   = 2'd3
  } mode_t;

  // What one feed step of the datapath does.
  typedef enum logic [2:0] {
    ACT_SILENT = 3'd0,
    ACT_PLAIN  = 3'd1,
    ACT_ESCAPE = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_FINISH = 3'd4
  } act_t;

  typedef struct packed {
    logic accept;
    logic feed;
    logic hex_hi;
    logic hex_lo;
    logic dump;
  } pcs_cmd_t;

  typedef struct packed {
    act_t act;
    logic dump_end;
    logic out_free;
  } pcs_status_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

  function automatic logic is_unres(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
           c == 8'h5F || c == 8'h7E;
  endfunction

  function automatic logic is_path_safe(input logic [7:0] c);
    return is_unres(c) || c == 8'h2F || c == 8'h2A || c == 8'h3F;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [7:0] lead);
    logic [2:0] r;
    r = 3'd0;
    if (lead < 8'h80) r = 3'd1;
    else if (lead < 8'hC0) r = 3'd0;
    else if (lead < 8'hE0) r = 3'd2;
    else if (lead < 8'hF0) r = 3'd3;
    else if (lead < 8'hF8) r = 3'd4;
    return r;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (lead == 8'hE0) lo = 8'hA0;
    if (lead == 8'hED) hi = 8'h9F;
    if (lead == 8'hF0) lo = 8'h90;
    if (lead == 8'hF4) hi = 8'h8F;
    return (lead >= 8'hC2) && (lead <= 8'hF4) && (b >= lo) && (b <= hi);
  endfunction

  // Number of escape characters that spell a sequence of the given length.
  function automatic logic [3:0] seq_chars(input logic [2:0] len);
    logic [3:0] r;
    case (len)
      3'd1:    r = 4'd3;
      3'd2:    r = 4'd6;
      3'd3:    r = 4'd9;
      3'd4:    r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/percent_codec_stream_core.sv
// Each input item takes an accept step, a feed step for its byte and a closing feed
// step, plus a step per output byte beyond the first: a byte written as %XX adds a
// high and a low hex-digit step. A completed escape in keep mode adds a dump step
// per held byte; a failed check adds the hex steps and a feed per replayed byte.
// Steps wait while the output stalls; each result waits in pend until the next one.
// Synchronous active-high reset: mode path encoding, stream state and queue empty.
module percent_codec_stream_core
  import pcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_error
);

  pcs_cmd_t    cmd;
  pcs_status_t status;
  logic [1:0]  mode_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {30'd0, mode_q};

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_mode       (pwdata[1:0]),
    .mode_q         (mode_q),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_error      (out_error)
  );

endmodule

### rtl/core/pcs_ctrl.sv
module pcs_ctrl
  import pcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  pcs_status_t status,
  output pcs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FEED   = 5'b00010,
    S_HEX_HI = 5'b00100,
    S_HEX_LO = 5'b01000,
    S_DUMP   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FEED;
        end
      end
      S_FEED: begin
        if (status.out_free) begin
          cmd.feed = 1'b1;
          case (status.act)
            ACT_ESCAPE: state_next = S_HEX_HI;
            ACT_DONE:   state_next = S_DUMP;
            ACT_FINISH: state_next = S_IDLE;
            default:    state_next = S_FEED;
          endcase
        end
      end
      S_HEX_HI: begin
        if (status.out_free) begin
          cmd.hex_hi = 1'b1;
          state_next = S_HEX_LO;
        end
      end
      S_HEX_LO: begin
        if (status.out_free) begin
          cmd.hex_lo = 1'b1;
          state_next = S_FEED;
        end
      end
      S_DUMP: begin
        cmd.dump = 1'b1;
        if (status.out_free && status.dump_end) state_next = S_FEED;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/pcs_datapath.sv
module pcs_datapath
  import pcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pcs_cmd_t    cmd,
  output pcs_status_t status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_mode,
  output logic [1:0]  mode_q,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_error
);

  logic [7:0]         queue [QueueDepth];
  logic [QueueAw-1:0] wr;
  logic [QueueAw-1:0] rd;
  logic [QueueAw-1:0] start;
  logic               last;
  mode_t              mode;
  logic [3:0]         count;
  logic [1:0]         kph;
  logic [2:0]         len;
  logic [7:0]         lead;
  logic [3:0]         hi_nib;
  logic [1:0]         phase;
  logic               failed;
  logic [7:0]         enc;
  logic [7:0]         pend;
  logic               pend_valid;

  logic [QueueAw-1:0] rd_next;
  logic [QueueAw-1:0] start_next;
  logic [3:0]         count_next;
  logic [1:0]         kph_next;
  logic [2:0]         len_next;
  logic [7:0]         lead_next;
  logic [3:0]         hi_nib_next;
  logic [1:0]         phase_next;
  logic               failed_next;
  logic [7:0]         enc_next;
  act_t               act;
  logic [7:0]         emit_byte;

  logic [7:0] rbyte;
  logic [4:0] hv;
  logic [7:0] val;
  logic [7:0] pc;
  logic [2:0] l_new;
  logic [2:0] l_eff;
  logic       ok;
  logic       empty;
  logic       out_free;
  logic       emit;
  logic       flush;

  assign mode_q   = mode;
  assign out_free = !out_valid || !out_stall;
  assign rbyte    = queue[cmd.dump ? start : rd];
  assign hv       = hex_val(rbyte);
  assign val      = {hi_nib, hv[3:0]};
  assign pc       = (rbyte == ChBslash) ? ChSlash : rbyte;
  assign empty    = (rd == wr);
  assign l_new    = utf8_len(val);
  assign l_eff    = (count == 4'd2) ? l_new : len;

  always_comb begin
    rd_next     = rd;
    start_next  = start;
    count_next  = count;
    kph_next    = kph;
    len_next    = len;
    lead_next   = lead;
    hi_nib_next = hi_nib;
    phase_next  = phase;
    failed_next = failed;
    enc_next    = enc;
    act         = ACT_SILENT;
    emit_byte   = ChPercent;
    ok          = 1'b1;
    if (empty) begin
      if (mode == MODE_KEEP && last && count != 4'd0) begin
        // The string ended inside an escape: its percent sign goes out encoded.
        act        = ACT_ESCAPE;
        enc_next   = ChPercent;
        rd_next    = start + 1'b1;
        count_next = 4'd0;
        len_next   = 3'd0;
      end else begin
        act = ACT_FINISH;
      end
    end else begin
      rd_next = rd + 1'b1;
      case (mode)
        MODE_PATH, MODE_COMP: begin
          if ((mode == MODE_PATH) ? is_path_safe(pc) : is_unres(rbyte)) begin
            act       = ACT_PLAIN;
            emit_byte = (mode == MODE_PATH) ? pc : rbyte;
          end else begin
            act      = ACT_ESCAPE;
            enc_next = (mode == MODE_PATH) ? pc : rbyte;
          end
        end
        MODE_DECODE: begin
          if (!failed) begin
            if (phase == 2'd0) begin
              if (rbyte == ChPercent) begin
                phase_next = 2'd1;
              end else begin
                act       = ACT_PLAIN;
                emit_byte = rbyte;
              end
            end else if (hv[4]) begin
              failed_next = 1'b1;
              phase_next  = 2'd0;
            end else if (phase == 2'd1) begin
              hi_nib_next = hv[3:0];
              phase_next  = 2'd2;
            end else begin
              act        = ACT_PLAIN;
              emit_byte  = val;
              phase_next = 2'd0;
            end
          end
        end
        default: begin
          if (count == 4'd0) begin
            if (rbyte == ChPercent) begin
              start_next = rd;
              count_next = 4'd1;
              kph_next   = 2'd1;
            end else if (is_path_safe(pc)) begin
              act       = ACT_PLAIN;
              emit_byte = pc;
            end else begin
              act      = ACT_ESCAPE;
              enc_next = pc;
            end
          end else begin
            count_next = count + 1'b1;
            kph_next   = (kph == 2'd2) ? 2'd0 : kph + 1'b1;
            if (kph == 2'd0) begin
              ok = (rbyte == ChPercent);
            end else if (kph == 2'd1) begin
              ok          = !hv[4];
              hi_nib_next = hv[3:0];
            end else begin
              ok = !hv[4];
              if (ok) begin
                if (count == 4'd2) begin
                  len_next  = l_new;
                  lead_next = val;
                  ok        = (l_new != 3'd0);
                end else if (count == 4'd5) begin
                  ok = second_ok(lead, val);
                end else begin
                  ok = (val[7:6] == 2'b10);
                end
              end
            end
            if (!ok) begin
              // Failed check: emit the percent sign as an escape and replay
              // the held text after it.
              act        = ACT_ESCAPE;
              enc_next   = ChPercent;
              rd_next    = start + 1'b1;
              count_next = 4'd0;
              len_next   = 3'd0;
            end else if (kph == 2'd2 && count + 1'b1 == seq_chars(l_eff)) begin
              act        = ACT_DONE;
              count_next = 4'd0;
              len_next   = 3'd0;
            end
          end
        end
      endcase
    end
  end

  assign status.act      = act;
  assign status.dump_end = (start + 1'b1 == rd);
  assign status.out_free = out_free;

  assign emit = (cmd.feed && (act == ACT_PLAIN || act == ACT_ESCAPE)) ||
                cmd.hex_hi || cmd.hex_lo || (cmd.dump && out_free);
  assign flush = cmd.feed && act == ACT_FINISH;

  logic [7:0] new_byte;
  always_comb begin
    new_byte = emit_byte;
    if (cmd.hex_hi) new_byte = hex_digit(enc[7:4]);
    else if (cmd.hex_lo) new_byte = hex_digit(enc[3:0]);
    else if (cmd.dump) new_byte = to_upper(rbyte);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) queue[wr] <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr         <= '0;
      rd         <= '0;
      start      <= '0;
      last       <= 1'b0;
      mode       <= MODE_PATH;
      count      <= 4'd0;
      kph        <= 2'd0;
      len        <= 3'd0;
      lead       <= 8'd0;
      hi_nib     <= 4'd0;
      phase      <= 2'd0;
      failed     <= 1'b0;
      enc        <= 8'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        mode   <= mode_t'(cfg_mode);
        rd     <= wr;
        start  <= wr;
        count  <= 4'd0;
        kph    <= 2'd0;
        len    <= 3'd0;
        hi_nib <= 4'd0;
        phase  <= 2'd0;
        failed <= 1'b0;
      end
      if (cmd.accept) begin
        wr   <= wr + 1'b1;
        last <= in_last;
      end
      if (cmd.feed) begin
        rd     <= rd_next;
        start  <= start_next;
        count  <= count_next;
        kph    <= kph_next;
        len    <= len_next;
        lead   <= lead_next;
        hi_nib <= hi_nib_next;
        phase  <= phase_next;
        failed <= failed_next;
        enc    <= enc_next;
        if (flush && last) begin
          count  <= 4'd0;
          kph    <= 2'd0;
          len    <= 3'd0;
          hi_nib <= 4'd0;
          phase  <= 2'd0;
          failed <= 1'b0;
        end
      end
      if (cmd.dump && out_free) start <= start + 1'b1;
      if (emit) begin
        pend       <= new_byte;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid      <= 1'b1;
          out_byte       <= pend;
          out_has_byte   <= 1'b1;
          out_run_last   <= 1'b0;
          out_string_end <= 1'b0;
          out_error      <= 1'b0;
        end
      end
      if (flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) begin
          out_valid      <= 1'b1;
          out_byte       <= pend;
          out_has_byte   <= 1'b1;
          out_run_last   <= 1'b1;
          out_string_end <= last;
          out_error      <= 1'b0;
        end else if (last) begin
          out_valid      <= 1'b1;
          out_byte       <= 8'd0;
          out_has_byte   <= 1'b0;
          out_run_last   <= 1'b1;
          out_string_end <= 1'b1;
          out_error      <= (mode == MODE_DECODE) && (failed || phase != 2'd0);
        end
      end
    end
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (rst) count <= 4'd11)
    else $error("held escape text exceeds its bound");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count != 4'd0 |-> QueueAw'(wr - start) <= QueueAw'(13))
    else $error("byte queue overrun");

  a_err_bare: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> !out_has_byte && out_string_end)
    else $error("error flag on a data item");

endmodule
